// ===== hdl/tcgp_pkg.sv =====
// ----------------------------------------------------------------------------
// tcgp_pkg
// Shared types and constants of the text cursor glyph placer.
// ----------------------------------------------------------------------------
package tcgp_pkg;

   localparam int TABLE_DEPTH = 128;
   localparam int IDX_W       = 7;
   localparam int CODE_W      = 8;
   localparam int CNT_W       = 8;
   localparam int CW_W        = 7;
   localparam int SW_W        = 12;
   localparam int COORD_W     = 16;
   localparam int GX_W        = 14;

   localparam logic [CODE_W-1:0] CODE_CR = 8'd13;
   localparam logic [CODE_W-1:0] CODE_LF = 8'd10;

   typedef enum logic [1:0] {
      MODE_TABLE = 2'd0,
      MODE_START = 2'd1,
      MODE_CHAR  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      REG_CHAR_WIDTH   = 3'd0,
      REG_CHAR_HEIGHT  = 3'd1,
      REG_SCREEN_WIDTH = 3'd2,
      REG_WRAP_ENABLE  = 3'd3,
      REG_LOOKUP_MODE  = 3'd4,
      REG_GLYPH_COUNT  = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_EMIT   = 3'b100
   } state_type;

   // glyph table write, broadcast to every cell
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  index;
      logic [CODE_W-1:0] value;
   } wr_type;

   // search request travelling along the cell row
   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] code;
      logic              found;
      logic [IDX_W-1:0]  idx;
   } probe_type;

endpackage

// ===== hdl/tcgp_cell.sv =====
// ----------------------------------------------------------------------------
// tcgp_cell
// One glyph table entry with its compare stage; passes the search request on.
// ----------------------------------------------------------------------------
module tcgp_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tcgp_pkg::wr_type          wr,
   input  logic [tcgp_pkg::CNT_W-1:0] glyph_count,
   input  tcgp_pkg::probe_type       probe_in,
   output tcgp_pkg::probe_type       probe_out
);
   import tcgp_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
   localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);

   logic [CODE_W-1:0] entry_ff;
   probe_type         probe_ff;
   probe_type         probe_in_w;
   logic              hit;

   always_comb begin
      hit = probe_in.valid && !probe_in.found && (MY_CNT < glyph_count) &&
            (entry_ff == probe_in.code);
      probe_in_w       = probe_in;
      probe_in_w.found = probe_in.found | hit;
      probe_in_w.idx   = hit ? MY_IDX : probe_in.idx;
   end

   always_ff @(posedge clock) begin
      if (wr.en && (wr.index == MY_IDX)) begin
         entry_ff <= wr.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in_w;
      end
   end

   assign probe_out = probe_ff;

endmodule

// ===== hdl/text_cursor_glyph_placer.sv =====
// ----------------------------------------------------------------------------
// text_cursor_glyph_placer
// Turns a stream of character codes into glyph blit requests.
// ----------------------------------------------------------------------------
// req channel: requests with tuser = mode (glyph table write, string start,
// character), tdata = start_x, start_y, table_index, code, tlast = last_char.
// rsp channel: one response per character request; tuser = draw, stopped,
// tdata = glyph_x, dest_x, dest_y, tlast = echo of last_char.
// csr port: apb-style registers char_width, char_height, screen_width,
// wrap_enable, lookup_mode, glyph_count at byte addresses 0, 4, .. 20.
// Table writes and starts do not leave the idle state and give no response. A
// character in direct mode passes through the request stage to the output
// register, and the next request is taken once it has reached the output
// register. In search mode the request first walks the row of glyph cells,
// one cell per cycle, before it enters the request stage; no further request
// is taken until it has reached the output register.
// While a response waits in the output register requests are still taken;
// a character then holds in the request stage and blocks the request side
// until the receiver takes the waiting response.
// Reset clears cursor, line origin, halt flag and registers to their defaults;
// the glyph table holds no reset value and must be written before a search.
// ----------------------------------------------------------------------------
module text_cursor_glyph_placer #(
   parameter int GLYPHS = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // start_x, start_y, table_index, code, pad
   input  logic [1:0]  req_tuser,   // mode
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // glyph_x, dest_x, dest_y, pad
   output logic [1:0]  rsp_tuser,   // draw, stopped
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tcgp_pkg::*;

   localparam int NCELL = (GLYPHS < TABLE_DEPTH) ? GLYPHS : TABLE_DEPTH;

   // registers
   logic [CW_W-1:0]   cw_ff, ch_ff;
   logic [SW_W-1:0]   sw_ff;
   logic              wrap_ff, mm_ff;
   logic [CNT_W-1:0]  gc_ff;
   reg_index_type     csr_idx;
   logic              csr_wr;

   // cursor state
   state_type            state_ff, state_in;
   logic [COORD_W-1:0]   cx_ff, cx_in, cy_ff, cy_in, org_ff, org_in;
   logic                 halted_ff, halted_in;

   // pending response
   logic                 pend_draw_ff, pend_draw_in;
   logic                 pend_stop_ff, pend_stop_in;
   logic                 pend_last_ff, pend_last_in;
   logic [CODE_W-1:0]    pend_idx_ff, pend_idx_in;
   logic [COORD_W-1:0]   pend_dx_ff, pend_dx_in, pend_dy_ff, pend_dy_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_draw_ff, out_draw_in, out_stop_ff, out_stop_in;
   logic                 out_last_ff, out_last_in;
   logic [GX_W-1:0]      out_gx_ff, out_gx_in;
   logic [COORD_W-1:0]   out_dx_ff, out_dx_in, out_dy_ff, out_dy_in;

   // request fields
   mode_type             req_mode;
   logic [COORD_W-1:0]   req_sx, req_sy;
   logic [IDX_W-1:0]     req_tidx;
   logic [CODE_W-1:0]    req_code;
   logic                 accept;

   logic [COORD_W-1:0]   cx_adv;
   logic [COORD_W+1:0]   ovf_sum;
   logic                 ovf;
   logic [CODE_W+CW_W-1:0] gx_prod;

   wr_type               wr;
   probe_type            probe_head;
   probe_type            probe_w [0:NCELL];

   // csr port
   assign csr_pready = 1'b1;
   assign csr_idx    = reg_index_type'(csr_paddr[4:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff   <= CW_W'(8);
         ch_ff   <= CW_W'(8);
         sw_ff   <= SW_W'(640);
         wrap_ff <= 1'b0;
         mm_ff   <= 1'b0;
         gc_ff   <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_CHAR_WIDTH:   cw_ff   <= csr_pwdata[CW_W-1:0];
            REG_CHAR_HEIGHT:  ch_ff   <= csr_pwdata[CW_W-1:0];
            REG_SCREEN_WIDTH: sw_ff   <= csr_pwdata[SW_W-1:0];
            REG_WRAP_ENABLE:  wrap_ff <= csr_pwdata[0];
            REG_LOOKUP_MODE:  mm_ff   <= csr_pwdata[0];
            REG_GLYPH_COUNT:  gc_ff   <= csr_pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_CHAR_WIDTH:   csr_prdata = {25'b0, cw_ff};
         REG_CHAR_HEIGHT:  csr_prdata = {25'b0, ch_ff};
         REG_SCREEN_WIDTH: csr_prdata = {20'b0, sw_ff};
         REG_WRAP_ENABLE:  csr_prdata = {31'b0, wrap_ff};
         REG_LOOKUP_MODE:  csr_prdata = {31'b0, mm_ff};
         REG_GLYPH_COUNT:  csr_prdata = {24'b0, gc_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // request fields
   assign req_mode = mode_type'(req_tuser);
   assign req_sx   = req_tdata[15:0];
   assign req_sy   = req_tdata[31:16];
   assign req_tidx = req_tdata[38:32];
   assign req_code = req_tdata[46:39];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // cursor advance and overflow test
   assign cx_adv  = cx_ff + {{(COORD_W-CW_W){1'b0}}, cw_ff};
   assign ovf_sum = {{2{cx_adv[COORD_W-1]}}, cx_adv} + {{(COORD_W+2-CW_W){1'b0}}, cw_ff};
   assign ovf     = $signed(ovf_sum) > $signed({{(COORD_W+2-SW_W){1'b0}}, sw_ff});

   assign gx_prod = pend_idx_ff * cw_ff;

   // glyph cell row
   assign probe_w[0] = probe_head;

   generate
      for (genvar i = 0; i < NCELL; i++) begin : g_cell
         tcgp_cell #(
            .CELL_IDX (i)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .wr          (wr),
            .glyph_count (gc_ff),
            .probe_in    (probe_w[i]),
            .probe_out   (probe_w[i+1])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      org_in       = org_ff;
      halted_in    = halted_ff;
      pend_draw_in = pend_draw_ff;
      pend_stop_in = pend_stop_ff;
      pend_last_in = pend_last_ff;
      pend_idx_in  = pend_idx_ff;
      pend_dx_in   = pend_dx_ff;
      pend_dy_in   = pend_dy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      out_draw_in  = out_draw_ff;
      out_stop_in  = out_stop_ff;
      out_last_in  = out_last_ff;
      out_gx_in    = out_gx_ff;
      out_dx_in    = out_dx_ff;
      out_dy_in    = out_dy_ff;
      wr           = '0;
      probe_head   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  MODE_TABLE: begin
                     wr.en    = 1'b1;
                     wr.index = req_tidx;
                     wr.value = req_code;
                  end
                  MODE_START: begin
                     cx_in     = req_sx;
                     cy_in     = req_sy;
                     org_in    = req_sx;
                     halted_in = 1'b0;
                  end
                  MODE_CHAR: begin
                     pend_last_in = req_tlast;
                     pend_stop_in = 1'b0;
                     pend_draw_in = 1'b0;
                     pend_idx_in  = '0;
                     pend_dx_in   = '0;
                     pend_dy_in   = '0;
                     state_in     = ST_EMIT;
                     if (halted_ff) begin
                        pend_stop_in = 1'b1;
                     end else if (req_code == CODE_CR) begin
                        cx_in = org_ff;
                     end else if (req_code == CODE_LF) begin
                        cx_in = org_ff;
                        cy_in = cy_ff + {{(COORD_W-CW_W){1'b0}}, ch_ff};
                     end else begin
                        pend_dx_in = cx_ff;
                        pend_dy_in = cy_ff;
                        cx_in      = cx_adv;
                        if (ovf) begin
                           if (wrap_ff) begin
                              cx_in = org_ff;
                              cy_in = cy_ff + {{(COORD_W-CW_W){1'b0}}, ch_ff};
                           end else begin
                              halted_in = 1'b1;
                           end
                        end
                        if (!mm_ff) begin
                           pend_draw_in = 1'b1;
                           pend_idx_in  = req_code;
                        end else begin
                           probe_head.valid = 1'b1;
                           probe_head.code  = req_code;
                           state_in         = ST_SEARCH;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SEARCH: begin
            if (probe_w[NCELL].valid) begin
               pend_draw_in = probe_w[NCELL].found;
               pend_idx_in  = {1'b0, probe_w[NCELL].idx};
               if (!probe_w[NCELL].found) begin
                  pend_dx_in = '0;
                  pend_dy_in = '0;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               out_draw_in  = pend_draw_ff;
               out_stop_in  = pend_stop_ff;
               out_last_in  = pend_last_ff;
               out_gx_in    = gx_prod[GX_W-1:0];
               out_dx_in    = pend_dx_ff;
               out_dy_in    = pend_dy_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cx_ff        <= '0;
         cy_ff        <= '0;
         org_ff       <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         org_ff       <= org_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_draw_ff <= pend_draw_in;
      pend_stop_ff <= pend_stop_in;
      pend_last_ff <= pend_last_in;
      pend_idx_ff  <= pend_idx_in;
      pend_dx_ff   <= pend_dx_in;
      pend_dy_ff   <= pend_dy_in;
      out_draw_ff  <= out_draw_in;
      out_stop_ff  <= out_stop_in;
      out_last_ff  <= out_last_in;
      out_gx_ff    <= out_gx_in;
      out_dx_ff    <= out_dx_in;
      out_dy_ff    <= out_dy_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b0, out_dy_ff, out_dx_ff, out_gx_ff};
   assign rsp_tuser  = {out_stop_ff, out_draw_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text cursor glyph placer. Directed rows cover
// reset defaults, carriage return and newline, coordinate wrap, overflow with
// and without line wrap, the dropped-string state, table search bounds, wide
// source offsets and a zero cell width. Random strings follow over a series
// of register settings, with random gaps and stalls on both streams and one
// long output stall. Each response is compared against an in-bench cursor
// and glyph table model, or for scripted characters a written-out value.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tcgp_pkg::*;

   localparam int LIMIT_CYCLES  = 2_000_000;
   localparam int SETTLE_CYCLES = 140;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_ITEMS  = 1500;
   localparam int PHASE_ITEMS   = 120;
   localparam int REPORT_LIMIT  = 10;

   localparam logic [1:0] MODE_IGNORED = 2'd3;

   typedef struct packed {
      logic               draw;
      logic [GX_W-1:0]    glyph_x;
      logic [COORD_W-1:0] dest_x;
      logic [COORD_W-1:0] dest_y;
      logic               tail;
      logic               stopped;
   } blit_type;

   typedef struct packed {
      logic               is_csr;
      reg_index_type      csr_index;
      logic [31:0]        csr_value;
      logic [1:0]         mode;
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [IDX_W-1:0]   table_index;
      logic [CODE_W-1:0]  code;
      logic               last_char;
      logic               typed;
      blit_type           want;
   } step_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata   = '0;   // start_x, start_y, table_index, code, pad
   logic [1:0]  req_tuser   = '0;   // mode
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [47:0] rsp_tdata;          // glyph_x, dest_x, dest_y, pad
   logic [1:0]  rsp_tuser;          // draw, stopped
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [4:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // cursor model
   logic [CW_W-1:0]    char_w;
   logic [CW_W-1:0]    char_h;
   logic [SW_W-1:0]    screen_w;
   logic               wrap_on;
   logic               search_on;
   logic [CNT_W-1:0]   glyph_cnt;
   logic [CODE_W-1:0]  glyph_mem [TABLE_DEPTH];
   logic [COORD_W-1:0] cursor_x;
   logic [COORD_W-1:0] cursor_y;
   logic [COORD_W-1:0] origin_x;
   logic               halted;

   blit_type pending_blits [$];
   step_type script [$];
   int       blit_mismatches = 0;
   int       cycle_count     = 0;
   bit       req_steady      = 1'b0;
   bit       rsp_steady      = 1'b0;
   bit       squeeze         = 1'b0;

   text_cursor_glyph_placer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   function automatic void apply_register(input reg_index_type r, input logic [31:0] v);
      case (r)
         REG_CHAR_WIDTH:   char_w    = v[CW_W-1:0];
         REG_CHAR_HEIGHT:  char_h    = v[CW_W-1:0];
         REG_SCREEN_WIDTH: screen_w  = v[SW_W-1:0];
         REG_WRAP_ENABLE:  wrap_on   = v[0];
         REG_LOOKUP_MODE:  search_on = v[0];
         REG_GLYPH_COUNT:  glyph_cnt = v[CNT_W-1:0];
         default: ;
      endcase
   endfunction

   // returns 1 when the request yields a response
   function automatic bit place_glyph(input logic [1:0] mode, input logic [15:0] sx,
                                      input logic [15:0] sy, input logic [6:0] idx,
                                      input logic [7:0] code, input logic lc,
                                      output blit_type res);
      int          hit;
      int          limit;
      logic [31:0] product;
      res      = '0;
      res.tail = lc;
      if (mode == MODE_TABLE) begin
         glyph_mem[idx] = code;
         return 1'b0;
      end
      if (mode == MODE_START) begin
         cursor_x = sx;
         cursor_y = sy;
         origin_x = sx;
         halted   = 1'b0;
         return 1'b0;
      end
      if (mode != MODE_CHAR)
         return 1'b0;
      if (halted) begin
         res.stopped = 1'b1;
         return 1'b1;
      end
      if (code == CODE_CR || code == CODE_LF) begin
         cursor_x = origin_x;
         if (code == CODE_LF)
            cursor_y = cursor_y + COORD_W'(char_h);
         return 1'b1;
      end
      hit = -1;
      if (!search_on) begin
         hit = int'(code);
      end else begin
         limit = (int'(glyph_cnt) < TABLE_DEPTH) ? int'(glyph_cnt) : TABLE_DEPTH;
         for (int i = 0; i < limit; i++)
            if (hit < 0 && glyph_mem[IDX_W'(i)] == code)
               hit = i;
      end
      if (hit >= 0) begin
         product     = hit * int'(char_w);
         res.draw    = 1'b1;
         res.glyph_x = product[GX_W-1:0];
         res.dest_x  = cursor_x;
         res.dest_y  = cursor_y;
      end
      cursor_x = cursor_x + COORD_W'(char_w);
      if (int'($signed(cursor_x)) + int'(char_w) > int'(screen_w)) begin
         if (wrap_on) begin
            cursor_x = origin_x;
            cursor_y = cursor_y + COORD_W'(char_h);
         end else begin
            halted = 1'b1;
         end
      end
      return 1'b1;
   endfunction

   function automatic int pick_gap(input bit steady);
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void script_request(input logic [1:0] m, input logic [15:0] x,
                                          input logic [15:0] y, input logic [6:0] i,
                                          input logic [7:0] c, input logic l);
      step_type s;
      s             = '0;
      s.mode        = m;
      s.start_x     = x;
      s.start_y     = y;
      s.table_index = i;
      s.code        = c;
      s.last_char   = l;
      script.push_back(s);
   endfunction

   function automatic void script_char(input logic [7:0] c, input logic l, input blit_type w);
      step_type s;
      s             = '0;
      s.mode        = MODE_CHAR;
      s.start_x     = COORD_W'($urandom);
      s.start_y     = COORD_W'($urandom);
      s.table_index = IDX_W'($urandom);
      s.code        = c;
      s.last_char   = l;
      s.typed       = 1'b1;
      s.want        = w;
      script.push_back(s);
   endfunction

   function automatic void script_write(input reg_index_type r, input logic [31:0] v);
      step_type s;
      s           = '0;
      s.is_csr    = 1'b1;
      s.csr_index = r;
      s.csr_value = v;
      script.push_back(s);
   endfunction

   task automatic send_request(input logic [1:0] mode, input logic [15:0] sx,
                               input logic [15:0] sy, input logic [6:0] idx,
                               input logic [7:0] code, input logic lc,
                               input logic typed, input blit_type want);
      blit_type res;
      int       gap;
      gap = pick_gap(req_steady);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {1'b0, code, idx, sy, sx};
      req_tlast  <= lc;
      do @(posedge clock); while (!req_tready);
      if (place_glyph(mode, sx, sy, idx, code, lc, res))
         pending_blits.push_back(typed ? want : res);
   endtask

   task automatic write_register(input reg_index_type r, input logic [31:0] v);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      apply_register(r, v);
   endtask

   // wait for all responses, then let a search still in flight finish
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (pending_blits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : check_blits
      blit_type got;
      blit_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.draw    = rsp_tuser[0];
         got.stopped = rsp_tuser[1];
         got.glyph_x = rsp_tdata[13:0];
         got.dest_x  = rsp_tdata[29:14];
         got.dest_y  = rsp_tdata[45:30];
         got.tail    = rsp_tlast;
         if (pending_blits.size() == 0) begin
            blit_mismatches++;
            if (blit_mismatches <= REPORT_LIMIT)
               $display("unexpected response: tdata %h tuser %b tlast %b",
                        rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want = pending_blits.pop_front();
            if (got.draw !== want.draw || got.glyph_x !== want.glyph_x ||
                got.dest_x !== want.dest_x || got.dest_y !== want.dest_y ||
                got.tail !== want.tail || got.stopped !== want.stopped) begin
               blit_mismatches++;
               if (blit_mismatches <= REPORT_LIMIT)
                  $display({"response mismatch (expected/actual): draw %0d/%0d ",
                            "glyph_x %0d/%0d dest_x %h/%h dest_y %h/%h ",
                            "last %0d/%0d stopped %0d/%0d"},
                           want.draw, got.draw, want.glyph_x, got.glyph_x,
                           want.dest_x, got.dest_x, want.dest_y, got.dest_y,
                           want.tail, got.tail, want.stopped, got.stopped);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAIL text_cursor_glyph_placer");
         $finish;
      end
   end

   initial begin : receiver
      int stall;
      wait (reset == 1'b0);
      forever begin
         if (squeeze) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            squeeze = 1'b0;
         end
         if ($urandom_range(0, 9) == 0)
            rsp_steady = !rsp_steady;
         stall = pick_gap(rsp_steady);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   initial begin : stimulus
      blit_type          none;
      int                items;
      int                phase;
      int                phase_end;
      int                r;
      int                len;
      bit                drop_last;
      logic [CW_W-1:0]   cw;
      logic [CW_W-1:0]   ch;
      logic [SW_W-1:0]   sw;
      logic              wr;
      logic              mm;
      logic [CNT_W-1:0]  gc;
      logic [15:0]       sx;
      logic [CODE_W-1:0] code;

      none      = '0;
      char_w    = 7'd8;
      char_h    = 7'd8;
      screen_w  = 12'd640;
      wrap_on   = 1'b0;
      search_on = 1'b0;
      glyph_cnt = '0;
      cursor_x  = '0;
      cursor_y  = '0;
      origin_x  = '0;
      halted    = 1'b0;

      // defaults after reset, direct mode, no wrap
      script_char(8'd65, 1'b0, {1'b1, 14'd520, 16'd0, 16'd0, 1'b0, 1'b0});
      script_char(8'd255, 1'b1, {1'b1, 14'd2040, 16'd8, 16'd0, 1'b1, 1'b0});
      script_char(CODE_CR, 1'b0, {1'b0, 14'd0, 16'd0, 16'd0, 1'b0, 1'b0});
      script_char(CODE_LF, 1'b1, {1'b0, 14'd0, 16'd0, 16'd0, 1'b1, 1'b0});
      script_request(MODE_START, 16'h8000, 16'h7fff, 7'h7f, 8'hff, 1'b1);
      script_char(8'd0, 1'b0, {1'b1, 14'd0, 16'h8000, 16'h7fff, 1'b0, 1'b0});
      script_char(CODE_LF, 1'b0, {1'b0, 14'd0, 16'd0, 16'd0, 1'b0, 1'b0});
      script_char(8'd1, 1'b1, {1'b1, 14'd8, 16'h8000, 16'h8007, 1'b1, 1'b0});
      // overflow without wrap, then dropped characters
      script_request(MODE_START, 16'd624, 16'd0, 7'd0, 8'd0, 1'b0);
      script_char(8'd120, 1'b0, {1'b1, 14'd960, 16'd624, 16'd0, 1'b0, 1'b0});
      script_char(8'd121, 1'b0, {1'b1, 14'd968, 16'd632, 16'd0, 1'b0, 1'b0});
      script_char(8'd122, 1'b1, {1'b0, 14'd0, 16'd0, 16'd0, 1'b1, 1'b1});
      script_char(CODE_LF, 1'b0, {1'b0, 14'd0, 16'd0, 16'd0, 1'b0, 1'b1});
      script_request(MODE_IGNORED, 16'hffff, 16'hffff, 7'h7f, 8'hff, 1'b1);
      // cursor crossing into negative x
      script_request(MODE_START, 16'h7ff8, 16'hffff, 7'd0, 8'd0, 1'b0);
      script_char(8'h80, 1'b0, {1'b1, 14'd1024, 16'h7ff8, 16'hffff, 1'b0, 1'b0});
      script_request(MODE_CHAR, COORD_W'($urandom), COORD_W'($urandom), IDX_W'($urandom),
                     8'h7f, 1'b1);
      // glyph table fill with distinct values, plus a duplicate and a far entry
      for (int i = 0; i < TABLE_DEPTH; i++)
         script_request(MODE_TABLE, COORD_W'($urandom), COORD_W'($urandom), IDX_W'(i),
                        CODE_W'(i * 3 + 1), 1'($urandom));
      script_request(MODE_TABLE, COORD_W'($urandom), COORD_W'($urandom), 7'd6, 8'd4, 1'b0);
      script_request(MODE_TABLE, COORD_W'($urandom), COORD_W'($urandom), 7'd127, 8'hef,
                     1'b1);
      // search mode with wrap
      script_write(REG_LOOKUP_MODE, 32'd1);
      script_write(REG_GLYPH_COUNT, 32'd4);
      script_write(REG_WRAP_ENABLE, 32'd1);
      script_write(REG_CHAR_WIDTH, 32'd64);
      script_write(REG_CHAR_HEIGHT, 32'd64);
      script_write(REG_SCREEN_WIDTH, 32'd200);
      script_request(MODE_START, 16'd0, 16'd0, 7'd0, 8'd0, 1'b0);
      script_request(MODE_CHAR, 16'd0, 16'd0, 7'd0, 8'd1, 1'b0);
      script_request(MODE_CHAR, 16'd0, 16'd0, 7'd0, 8'd4, 1'b0);
      script_request(MODE_CHAR, 16'd0, 16'd0, 7'd0, 8'd200, 1'b0);
      script_request(MODE_CHAR, 16'd0, 16'd0, 7'd0, 8'd7, 1'b1);
      script_request(MODE_CHAR, 16'd0, 16'd0, 7'd0, CODE_CR, 1'b0);
      // search bound above and below the table depth, and a zero count
      script_write(REG_GLYPH_COUNT, 32'd255);
      script_request(MODE_CHAR, 16'd0, 16'd0, 7'd0, 8'hef, 1'b0);
      script_write(REG_GLYPH_COUNT, 32'd127);
      script_request(MODE_CHAR, 16'd0, 16'd0, 7'd0, 8'hef, 1'b0);
      script_write(REG_GLYPH_COUNT, 32'd0);
      script_request(MODE_CHAR, 16'd0, 16'd0, 7'd0, 8'd1, 1'b0);
      // raw register widths: wide offsets and a zero cell width
      script_write(REG_CHAR_WIDTH, 32'd127);
      script_write(REG_GLYPH_COUNT, 32'd128);
      script_request(MODE_CHAR, 16'd0, 16'd0, 7'd0, 8'hef, 1'b0);
      script_write(REG_LOOKUP_MODE, 32'd0);
      script_request(MODE_CHAR, 16'd0, 16'd0, 7'd0, 8'd255, 1'b0);
      script_write(REG_CHAR_WIDTH, 32'd0);
      script_request(MODE_CHAR, 16'd0, 16'd0, 7'd0, 8'd5, 1'b0);
      script_request(MODE_CHAR, 16'd0, 16'd0, 7'd0, 8'd6, 1'b1);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (script[k]) begin
         if (script[k].is_csr) begin
            if (k == 0 || !script[k-1].is_csr)
               settle_block();
            write_register(script[k].csr_index, script[k].csr_value);
         end else begin
            send_request(script[k].mode, script[k].start_x, script[k].start_y,
                         script[k].table_index, script[k].code, script[k].last_char,
                         script[k].typed, script[k].want);
         end
      end

      items = 0;
      phase = 0;
      while (items < RANDOM_ITEMS) begin
         settle_block();
         case (phase)
            0: begin
               cw = 7'd1;  ch = 7'd1;  sw = 12'd1;    wr = 1'b0; mm = 1'b0; gc = 8'd0;
            end
            1: begin
               cw = 7'd64; ch = 7'd64; sw = 12'd4095; wr = 1'b1; mm = 1'b1; gc = 8'd128;
            end
            default: begin
               cw = ($urandom_range(0, 9) == 0) ? 7'd64 : 7'($urandom_range(1, 64));
               ch = 7'($urandom_range(1, 64));
               sw = ($urandom_range(0, 4) == 0) ? 12'd4095 : 12'($urandom_range(1, 4095));
               wr = 1'($urandom_range(0, 1));
               mm = (phase == 2) ? 1'b0 : 1'($urandom_range(0, 1));
               gc = ($urandom_range(0, 5) == 0) ? 8'd128 : 8'($urandom_range(0, 128));
            end
         endcase
         write_register(REG_CHAR_WIDTH, 32'(cw));
         write_register(REG_CHAR_HEIGHT, 32'(ch));
         write_register(REG_SCREEN_WIDTH, 32'(sw));
         write_register(REG_WRAP_ENABLE, 32'(wr));
         write_register(REG_LOOKUP_MODE, 32'(mm));
         write_register(REG_GLYPH_COUNT, 32'(gc));
         // back-to-back characters against a long output stall
         if (phase == 2) begin
            req_steady = 1'b1;
            squeeze    = 1'b1;
         end
         phase_end = items + PHASE_ITEMS;
         while (items < phase_end) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
               code = ($urandom_range(0, 1) == 0) ?
                      glyph_mem[IDX_W'($urandom_range(0, 127))] : CODE_W'($urandom);
               send_request(MODE_TABLE, COORD_W'($urandom), COORD_W'($urandom),
                            IDX_W'($urandom), code, 1'($urandom), 1'b0, none);
               items++;
            end else if (r < 11) begin
               send_request(MODE_IGNORED, COORD_W'($urandom), COORD_W'($urandom),
                            IDX_W'($urandom), CODE_W'($urandom), 1'($urandom), 1'b0, none);
            end else begin
               if ($urandom_range(0, 9) != 0) begin
                  sx = ($urandom_range(0, 9) < 6) ? 16'($urandom_range(0, screen_w))
                                                  : 16'($urandom);
                  send_request(MODE_START, sx, COORD_W'($urandom), IDX_W'($urandom),
                               CODE_W'($urandom), 1'($urandom), 1'b0, none);
                  items++;
               end
               len       = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                       : $urandom_range(1, 16);
               drop_last = ($urandom_range(0, 9) == 0);
               for (int n = 0; n < len; n++) begin
                  r = $urandom_range(0, 99);
                  if (r < 6)
                     code = CODE_CR;
                  else if (r < 12)
                     code = CODE_LF;
                  else if (r < 55)
                     code = glyph_mem[IDX_W'($urandom_range(0, 127))];
                  else
                     code = CODE_W'($urandom);
                  send_request(MODE_CHAR, COORD_W'($urandom), COORD_W'($urandom),
                               IDX_W'($urandom), code, (n == len - 1) && !drop_last,
                               1'b0, none);
                  items++;
               end
               if (!squeeze && $urandom_range(0, 3) == 0)
                  req_steady = !req_steady;
            end
         end
         phase++;
      end
      settle_block();

      if (blit_mismatches == 0 && pending_blits.size() == 0)
         $display("PASS text_cursor_glyph_placer");
      else
         $display("FAIL text_cursor_glyph_placer");
      $finish;
   end

endmodule
